>>> src/segi_pkg.sv
// Package for the segment intersection block.
// Holds the shared cell payload type; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package segi_pkg;

	localparam int CW = 16;
	localparam int DW = CW + 1;
	localparam int XW = 2 * CW + 4;
	localparam int PW = XW + DW;

	typedef struct packed {
		logic          vld;
		logic          hit;
		logic          rx_neg;
		logic          rz_neg;
		logic [CW-1:0] p0x;
		logic [CW-1:0] p0z;
		logic [XW-1:0] dv;
		logic [PW-1:0] remx;
		logic [PW-1:0] remz;
		logic [DW-1:0] qx;
		logic [DW-1:0] qz;
	} cell_t;

endpackage
`default_nettype wire

>>> src/segi_front.sv
// Front end: differences, cross products, hit test and scaled numerators.
// Depends on segi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module segi_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic signed [segi_pkg::CW-1:0] p0_x,
	input  wire logic signed [segi_pkg::CW-1:0] p0_z,
	input  wire logic signed [segi_pkg::CW-1:0] p1_x,
	input  wire logic signed [segi_pkg::CW-1:0] p1_z,
	input  wire logic signed [segi_pkg::CW-1:0] q0_x,
	input  wire logic signed [segi_pkg::CW-1:0] q0_z,
	input  wire logic signed [segi_pkg::CW-1:0] q1_x,
	input  wire logic signed [segi_pkg::CW-1:0] q1_z,
	output segi_pkg::cell_t                  cell_out
);
	localparam int CW = segi_pkg::CW;
	localparam int DW = segi_pkg::DW;
	localparam int XW = segi_pkg::XW;
	localparam int PW = segi_pkg::PW;

	logic signed [DW-1:0] rx, rz, sx, sz, wx, wz;
	logic vld_s1;
	logic signed [DW-1:0] rx_s1, rz_s1;
	logic [CW-1:0] p0x_s1, p0z_s1;
	logic signed [2*DW-1:0] a_s1, b_s1, c_s1, e_s1, f_s1, g_s1;
	logic signed [XW-1:0] d, nl, nm, dp, nlp, nmp;
	logic ok;
	logic vld_s2, hit_s2, rxn_s2, rzn_s2;
	logic [CW-1:0] p0x_s2, p0z_s2;
	logic [XW-1:0] d_s2, nl_s2;
	logic [DW-1:0] arx_s2, arz_s2;
	logic [PW-1:0] nx_s3, nz_s3;
	logic vld_s3, hit_s3, rxn_s3, rzn_s3;
	logic [CW-1:0] p0x_s3, p0z_s3;
	logic [XW-1:0] d_s3;

	always_comb begin
		rx = DW'(p1_x) - DW'(p0_x);
		rz = DW'(p1_z) - DW'(p0_z);
		sx = DW'(q1_x) - DW'(q0_x);
		sz = DW'(q1_z) - DW'(q0_z);
		wx = DW'(q0_x) - DW'(p0_x);
		wz = DW'(q0_z) - DW'(p0_z);
		rx[DW-1] = (p1_x[CW-1] ^ p0_x[CW-1]) ? p1_x[CW-1] : rx[DW-1];
		rz[DW-1] = (p1_z[CW-1] ^ p0_z[CW-1]) ? p1_z[CW-1] : rz[DW-1];
		sx[DW-1] = (q1_x[CW-1] ^ q0_x[CW-1]) ? q1_x[CW-1] : sx[DW-1];
		sz[DW-1] = (q1_z[CW-1] ^ q0_z[CW-1]) ? q1_z[CW-1] : sz[DW-1];
		wx[DW-1] = (q0_x[CW-1] ^ p0_x[CW-1]) ? q0_x[CW-1] : wx[DW-1];
		wz[DW-1] = (q0_z[CW-1] ^ p0_z[CW-1]) ? q0_z[CW-1] : wz[DW-1];
	end

	always_ff @(posedge clk) begin
		a_s1 <= rx * sz;
		b_s1 <= rz * sx;
		c_s1 <= wx * sz;
		e_s1 <= wz * sx;
		f_s1 <= wx * rz;
		g_s1 <= wz * rx;
		rx_s1 <= rx;
		rz_s1 <= rz;
		p0x_s1 <= p0_x;
		p0z_s1 <= p0_z;
	end

	always_comb begin
		d  = XW'(a_s1) - XW'(b_s1);
		nl = XW'(c_s1) - XW'(e_s1);
		nm = XW'(f_s1) - XW'(g_s1);
		dp  = d[XW-1] ? -d : d;
		nlp = d[XW-1] ? -nl : nl;
		nmp = d[XW-1] ? -nm : nm;
		ok = (d != '0) && !nlp[XW-1] && !nmp[XW-1] && (nlp <= dp) && (nmp <= dp);
	end

	always_ff @(posedge clk) begin
		d_s2 <= dp;
		nl_s2 <= nlp;
		hit_s2 <= ok;
		rxn_s2 <= rx_s1[DW-1];
		rzn_s2 <= rz_s1[DW-1];
		arx_s2 <= rx_s1[DW-1] ? -rx_s1 : rx_s1;
		arz_s2 <= rz_s1[DW-1] ? -rz_s1 : rz_s1;
		p0x_s2 <= p0x_s1;
		p0z_s2 <= p0z_s1;
	end

	always_ff @(posedge clk) begin
		nx_s3 <= nl_s2 * arx_s2;
		nz_s3 <= nl_s2 * arz_s2;
		d_s3 <= d_s2;
		hit_s3 <= hit_s2;
		rxn_s3 <= rxn_s2;
		rzn_s3 <= rzn_s2;
		p0x_s3 <= p0x_s2;
		p0z_s3 <= p0z_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_comb begin
		cell_out.vld    = vld_s3;
		cell_out.hit    = hit_s3;
		cell_out.rx_neg = rxn_s3;
		cell_out.rz_neg = rzn_s3;
		cell_out.p0x    = p0x_s3;
		cell_out.p0z    = p0z_s3;
		cell_out.dv     = d_s3;
		cell_out.remx   = nx_s3;
		cell_out.remz   = nz_s3;
		cell_out.qx     = '0;
		cell_out.qz     = '0;
	end
endmodule
`default_nettype wire

>>> src/segi_cell.sv
// One restoring division cell: settles one quotient bit per coordinate.
// Depends on segi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module segi_cell #(
	parameter int BIT = 0
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  segi_pkg::cell_t      cell_in,
	output segi_pkg::cell_t      cell_out
);
	localparam int PW = segi_pkg::PW;
	localparam int SW = PW + segi_pkg::DW;

	segi_pkg::cell_t nxt;
	segi_pkg::cell_t data_q;
	logic vld_q;
	logic [SW-1:0] dsh;
	logic gx, gz;

	always_comb begin
		nxt = cell_in;
		dsh = SW'(cell_in.dv) << BIT;
		gx = {segi_pkg::DW'(0), cell_in.remx} >= dsh;
		gz = {segi_pkg::DW'(0), cell_in.remz} >= dsh;
		if (gx) begin
			nxt.remx = cell_in.remx - PW'(dsh);
		end
		if (gz) begin
			nxt.remz = cell_in.remz - PW'(dsh);
		end
		nxt.qx[BIT] = gx;
		nxt.qz[BIT] = gz;
	end

	always_ff @(posedge clk) begin
		data_q <= nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= cell_in.vld;
		end
	end

	always_comb begin
		cell_out = data_q;
		cell_out.vld = vld_q;
	end
endmodule
`default_nettype wire

>>> src/segment_intersection.sv
// Top level of the segment intersection block.
// Depends on segi_pkg, segi_front and segi_cell.
// Usage: raise start for one cycle with both segments on the coordinate
// ports; busy is always low, so a request may be given in every cycle.
// The front end forms the differences, cross products, hit test and the
// scaled numerators in three stages. A chain of DW division cells (one
// quotient bit each, most significant first) then divides by the positive
// denominator, and a final stage adds the signed quotient to p0.
// Throughput is one request per cycle, since every stage and every cell
// takes a new request in each cycle.
// Each result stands on hit, cross_x and cross_z for exactly the one cycle
// in which done is high; the receiver cannot stall it.
// Reset clears all valid flags, so no strobe follows reset until a request.
`timescale 1ns / 1ps
`default_nettype none
module segment_intersection (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic signed [segi_pkg::CW-1:0] p0_x,
	input  wire logic signed [segi_pkg::CW-1:0] p0_z,
	input  wire logic signed [segi_pkg::CW-1:0] p1_x,
	input  wire logic signed [segi_pkg::CW-1:0] p1_z,
	input  wire logic signed [segi_pkg::CW-1:0] q0_x,
	input  wire logic signed [segi_pkg::CW-1:0] q0_z,
	input  wire logic signed [segi_pkg::CW-1:0] q1_x,
	input  wire logic signed [segi_pkg::CW-1:0] q1_z,
	output logic                                done,
	output logic                                hit,
	output logic signed [segi_pkg::CW-1:0]      cross_x,
	output logic signed [segi_pkg::CW-1:0]      cross_z
);
	localparam int DW = segi_pkg::DW;
	localparam int CW = segi_pkg::CW;

	segi_pkg::cell_t chain [0:DW];
	logic [CW-1:0] ox_q, oz_q;
	logic hit_q, done_q;

	assign busy = 1'b0;

	segi_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start),
		.p0_x(p0_x), .p0_z(p0_z), .p1_x(p1_x), .p1_z(p1_z),
		.q0_x(q0_x), .q0_z(q0_z), .q1_x(q1_x), .q1_z(q1_z),
		.cell_out(chain[0])
	);

	for (genvar i = 0; i < DW; i++) begin : g_cell
		segi_cell #(.BIT(DW - 1 - i)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.cell_in(chain[i]), .cell_out(chain[i+1])
		);
	end

	always_ff @(posedge clk) begin
		hit_q <= chain[DW].hit;
		ox_q <= chain[DW].hit ? (chain[DW].rx_neg ? chain[DW].p0x - CW'(chain[DW].qx)
		                                          : chain[DW].p0x + CW'(chain[DW].qx)) : '0;
		oz_q <= chain[DW].hit ? (chain[DW].rz_neg ? chain[DW].p0z - CW'(chain[DW].qz)
		                                          : chain[DW].p0z + CW'(chain[DW].qz)) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= chain[DW].vld;
		end
	end

	assign done = done_q;
	assign hit = hit_q;
	assign cross_x = ox_q;
	assign cross_z = oz_q;
endmodule
`default_nettype wire

>>> src/segi_checker.sv
// Port checker for the segment intersection block, bound to the top level.
// Depends on segi_pkg and segment_intersection.
`timescale 1ns / 1ps
`default_nettype none
module segi_checker (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    start,
	input wire logic                    busy,
	input wire logic                    done,
	input wire logic                    hit,
	input wire logic [segi_pkg::CW-1:0] cross_x,
	input wire logic [segi_pkg::CW-1:0] cross_z
);
	localparam int LAT = segi_pkg::DW + 4;

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit |-> cross_x == '0 && cross_z == '0) else $error("miss not zero");
	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("busy raised");
	a_done_lat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT)) else $error("strobe without request");
	a_req_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done) else $error("request lost");
endmodule

bind segment_intersection segi_checker u_segi_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.hit(hit), .cross_x(cross_x), .cross_z(cross_z)
);
`default_nettype wire
